>>> src/rsv_pkg.sv
// ----------------------------------------------------------------------------
// rsv_pkg - shared types and constants of the rna structure validator
// Request and result payload structs, verdict codes, character codes and
// the base classification and pairing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rsv_pkg;

  // default strand length limit (stack depth)
  localparam int MAX_LEN_DEF = 4096;

  // widths fixed by the payload
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 12;
  localparam int STATUS_W = 3;

  // verdict codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PAIR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd5;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h55;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;

  typedef struct packed {
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] bracket;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   open_base;
    logic [CHAR_W-1:0]   close_base;
  } result_t;

  // stack control from the strand checker
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [CHAR_W-1:0] data;
  } stack_ctrl_t;

  // stack status towards the strand checker
  typedef struct packed {
    logic              empty;
    logic              single;
    logic [CHAR_W-1:0] top;
  } stack_stat_t;

  function automatic logic base_ok(input logic [CHAR_W-1:0] c);
    return c inside {CH_G, CH_C, CH_A, CH_U, CH_T};
  endfunction

  function automatic logic pair_ok(input logic [CHAR_W-1:0] o,
                                   input logic [CHAR_W-1:0] c);
    return (o == CH_A && c == CH_U) || (o == CH_C && c == CH_G) ||
           (o == CH_G && c == CH_C) || (o == CH_G && c == CH_U) ||
           (o == CH_U && c == CH_G) || (o == CH_U && c == CH_A);
  endfunction

endpackage

`default_nettype wire

>>> src/rsv_stack.sv
// ----------------------------------------------------------------------------
// rsv_stack - open-bracket stack
// Memory of open bases with a fill counter. The entry under the next fill
// is read every cycle into a register, with a bypass for a fresh push, so
// the top of stack is ready for a pop in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsv_stack #(
  parameter int MAX_LEN = rsv_pkg::MAX_LEN_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  rsv_pkg::stack_ctrl_t ctrl,
  output rsv_pkg::stack_stat_t stat
);

  localparam int FILL_W = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  logic [rsv_pkg::CHAR_W-1:0] mem [MAX_LEN];
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_next;
  logic [FILL_W-1:0]          top_idx;
  logic [ADDR_W-1:0]          rd_addr;
  logic [rsv_pkg::CHAR_W-1:0] rd_data;
  logic                       bypass;
  logic [rsv_pkg::CHAR_W-1:0] bypass_data;

  // fill counter update
  always_comb begin
    if (ctrl.clear) begin
      fill_next = '0;
    end else if (ctrl.push) begin
      fill_next = fill + FILL_W'(1);
    end else if (ctrl.pop) begin
      fill_next = fill - FILL_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  assign top_idx = fill_next - FILL_W'(1);
  assign rd_addr = top_idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      bypass <= 1'b0;
    end else begin
      fill   <= fill_next;
      bypass <= ctrl.push;
    end
  end

  // memory write and registered read of the next top entry
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[fill[ADDR_W-1:0]] <= ctrl.data;
    end
    rd_data     <= mem[rd_addr];
    bypass_data <= ctrl.data;
  end

  assign stat.empty  = (fill == '0);
  assign stat.single = (fill == FILL_W'(1));
  assign stat.top    = bypass ? bypass_data : rd_data;

endmodule

`default_nettype wire

>>> src/rsv_strand.sv
// ----------------------------------------------------------------------------
// rsv_strand - per-strand checker
// Position counter, first sequence fault, first structure fault and the
// overflow flag; drives the stack and forms the verdict on the last item.
// ----------------------------------------------------------------------------
`default_nettype none

module rsv_strand #(
  parameter int MAX_LEN = rsv_pkg::MAX_LEN_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  advance,
  input  rsv_pkg::item_t       item,
  input  wire                  check,
  input  rsv_pkg::stack_stat_t stat,
  output rsv_pkg::stack_ctrl_t ctrl,
  output rsv_pkg::result_t     verdict
);

  localparam int IDX_W  = $clog2(MAX_LEN + 1);
  localparam int POS_W  = rsv_pkg::POS_W;
  localparam int CHAR_W = rsv_pkg::CHAR_W;

  logic [IDX_W-1:0]         idx, idx_next;
  logic                     seq_valid, seq_valid_next;
  logic [POS_W-1:0]         seq_pos, seq_pos_next;
  logic [CHAR_W-1:0]        seq_char, seq_char_next;
  logic                     pair_valid, pair_valid_next;
  logic [rsv_pkg::STATUS_W-1:0] pair_kind, pair_kind_next;
  logic [POS_W-1:0]         pair_pos, pair_pos_next;
  logic [CHAR_W-1:0]        pair_open, pair_open_next;
  logic [CHAR_W-1:0]        pair_close, pair_close_next;
  logic                     overflow, overflow_next;

  logic                     examined;
  logic                     act;
  logic                     is_open;
  logic                     is_close;
  logic                     filled_after;
  logic [IDX_W+POS_W-1:0]   pos_wide;
  logic [POS_W-1:0]         pos;

  assign examined = (idx < IDX_W'(MAX_LEN));
  assign act      = examined && check && !pair_valid;
  assign is_open  = act && (item.bracket == rsv_pkg::CH_OPEN);
  assign is_close = act && (item.bracket == rsv_pkg::CH_CLOSE);
  assign pos_wide = {{POS_W{1'b0}}, idx};
  assign pos      = pos_wide[POS_W-1:0];

  // stack requests
  assign ctrl.push  = advance && is_open;
  assign ctrl.pop   = advance && is_close && !stat.empty;
  assign ctrl.clear = advance && item.last;
  assign ctrl.data  = item.base;

  // fault capture for the current item
  always_comb begin
    idx_next        = idx;
    seq_valid_next  = seq_valid;
    seq_pos_next    = seq_pos;
    seq_char_next   = seq_char;
    pair_valid_next = pair_valid;
    pair_kind_next  = pair_kind;
    pair_pos_next   = pair_pos;
    pair_open_next  = pair_open;
    pair_close_next = pair_close;
    overflow_next   = overflow;
    if (!examined) begin
      overflow_next = 1'b1;
    end else begin
      idx_next = idx + IDX_W'(1);
      if (!rsv_pkg::base_ok(item.base) && !seq_valid) begin
        seq_valid_next = 1'b1;
        seq_pos_next   = pos;
        seq_char_next  = item.base;
      end
      if (is_close) begin
        if (stat.empty) begin
          pair_valid_next = 1'b1;
          pair_kind_next  = rsv_pkg::ST_NO_OPEN;
          pair_pos_next   = pos;
          pair_open_next  = '0;
          pair_close_next = '0;
        end else if (!rsv_pkg::pair_ok(stat.top, item.base)) begin
          pair_valid_next = 1'b1;
          pair_kind_next  = rsv_pkg::ST_NO_PAIR;
          pair_pos_next   = pos;
          pair_open_next  = stat.top;
          pair_close_next = item.base;
        end
      end
    end
  end

  // stack occupancy once this item is applied
  always_comb begin
    if (is_open) begin
      filled_after = 1'b1;
    end else if (is_close && !stat.empty) begin
      filled_after = !stat.single;
    end else begin
      filled_after = !stat.empty;
    end
  end

  // verdict by priority
  always_comb begin
    verdict = '0;
    if (seq_valid_next) begin
      verdict.status     = rsv_pkg::ST_BAD_BASE;
      verdict.position   = seq_pos_next;
      verdict.close_base = seq_char_next;
    end else if (pair_valid_next) begin
      verdict.status   = pair_kind_next;
      verdict.position = pair_pos_next;
      if (pair_kind_next == rsv_pkg::ST_NO_PAIR) begin
        verdict.open_base  = pair_open_next;
        verdict.close_base = pair_close_next;
      end
    end else if (overflow_next) begin
      verdict.status = rsv_pkg::ST_TOO_LONG;
    end else if (check && filled_after) begin
      verdict.status = rsv_pkg::ST_UNCLOSED;
    end
  end

  // strand state, cleared after the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      seq_valid  <= 1'b0;
      pair_valid <= 1'b0;
      overflow   <= 1'b0;
    end else if (advance) begin
      if (item.last) begin
        idx        <= '0;
        seq_valid  <= 1'b0;
        pair_valid <= 1'b0;
        overflow   <= 1'b0;
      end else begin
        idx        <= idx_next;
        seq_valid  <= seq_valid_next;
        pair_valid <= pair_valid_next;
        overflow   <= overflow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seq_pos    <= seq_pos_next;
      seq_char   <= seq_char_next;
      pair_kind  <= pair_kind_next;
      pair_pos   <= pair_pos_next;
      pair_open  <= pair_open_next;
      pair_close <= pair_close_next;
    end
  end

endmodule

`default_nettype wire

>>> src/rna_structure_validator_top.sv
// ----------------------------------------------------------------------------
// rna_structure_validator_top - rna sequence and dot-bracket checker
//
// One request per strand position: base byte, structure byte, last flag,
// on a valid/ready channel. A strand gives one result, on its last request:
// status, offending position, and the bases involved. Results leave on a
// valid/ready channel; requests without last give no result.
// A request is registered, checked against the strand state and the open
// bracket stack combinationally, and its verdict registered: a result is
// valid once its last request has passed the input and result registers.
// Throughput is one request per cycle while no untaken result holds the
// result register; the stack memory is read every cycle at the next top
// entry, so back-to-back pushes and pops run at full rate.
// When the result register holds an untaken result, the checking stage
// waits; one more request is held in the input register before item_ready
// falls.
// Reset empties the stack and strand state and sets check to 1;
// the stack memory itself is not cleared. cfg_we writes check.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_structure_validator_top #(
  parameter int MAX_LEN = rsv_pkg::MAX_LEN_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire               cfg_data,
  input  wire               item_valid,
  output logic              item_ready,
  input  rsv_pkg::item_t    item,
  output logic              result_valid,
  input  wire               result_ready,
  output rsv_pkg::result_t  result
);

  logic                 check;
  logic                 s1_valid;
  rsv_pkg::item_t       s1_item;
  logic                 advance;
  rsv_pkg::stack_ctrl_t ctrl;
  rsv_pkg::stack_stat_t stat;
  rsv_pkg::result_t     verdict;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      check <= 1'b1;
    end else if (cfg_we) begin
      check <= cfg_data;
    end
  end

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  rsv_strand #(
    .MAX_LEN (MAX_LEN)
  ) u_strand (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .check   (check),
    .stat    (stat),
    .ctrl    (ctrl),
    .verdict (verdict)
  );

  rsv_stack #(
    .MAX_LEN (MAX_LEN)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s1_item.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item.last) begin
      result <= verdict;
    end
  end

  // a last request always turns into a result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.last |=> result_valid)
    else $error("last request gave no result");

  // open base only reported for a pairing fault
  a_open_base_pair_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != rsv_pkg::ST_NO_PAIR |-> result.open_base == '0)
    else $error("open base set outside pairing fault");

  // verdicts without a located fault carry no position or character
  a_no_position: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == rsv_pkg::ST_OK ||
                     result.status == rsv_pkg::ST_UNCLOSED ||
                     result.status == rsv_pkg::ST_TOO_LONG)
    |-> result.position == '0 && result.close_base == '0)
    else $error("position or character set on unlocated verdict");

  // stack never popped and pushed at once
  a_stack_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && ctrl.pop))
    else $error("stack push and pop together");

endmodule

`default_nettype wire
